// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, held off while reset is low.
`define ASSERT_AT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("assertion failed");

// Assert that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== rtl/core/ipq_pkg.sv =====
// Types and constants for the indexed priority queue.
package ipq_pkg;

	localparam int ENTRIES  = 64;
	localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HANDLE_W = 6;
	localparam int PRIO_W   = 16;
	localparam int STAMP_W  = 32;

	// command queue between front and back, power of two deep
	localparam int CQ_DEPTH = 4;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_RAISE  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_UNKNOWN = 2'd2,
		STAT_PRESENT = 2'd3
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   amount;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] top_handle;
		logic [PRIO_W-1:0]   top_priority;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t               op;
		logic              in_range;
		logic [IDX_W-1:0]  idx;
		logic [PRIO_W-1:0] amount;
	} cmd_t;

	// one table entry
	typedef struct packed {
		logic [PRIO_W-1:0]  prio;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

// ===== rtl/core/ipq_cmd_fifo.sv =====
// Short command queue between the front and back parts.
module ipq_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ipq_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ipq_pkg::cmd_t pop_cmd
);

	ipq_pkg::cmd_t                 slots_q [ipq_pkg::CQ_DEPTH];
	logic [ipq_pkg::CQ_PTR_W-1:0]  wr_ptr_q;
	logic [ipq_pkg::CQ_PTR_W-1:0]  rd_ptr_q;
	logic [ipq_pkg::CQ_PTR_W:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != (ipq_pkg::CQ_PTR_W + 1)'(ipq_pkg::CQ_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slots_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// store pushed words
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/ipq_front.sv =====
// Front part: accepts request words and classifies them into commands.
module ipq_front (
	input  logic          req_valid,
	output logic          req_ready,
	input  ipq_pkg::req_t req,
	output logic          push_valid,
	input  logic          push_ready,
	output ipq_pkg::cmd_t push_cmd
);

	// pass the handshake straight to the queue
	assign push_valid = req_valid;
	assign req_ready  = push_ready;

	// decode handle into a table index and range flag
	always_comb begin
		push_cmd          = '0;
		push_cmd.op       = req.op;
		push_cmd.amount   = req.amount;
		push_cmd.idx      = ipq_pkg::IDX_W'(req.handle);
		push_cmd.in_range = (int'(req.handle) < ipq_pkg::ENTRIES);
	end

endmodule

// ===== rtl/core/ipq_back.sv =====
// Back part: table memory, valid bits, arrival counter and command sequencer.
module ipq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ipq_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ipq_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_RAISE = 3'b010,
		S_SCAN  = 3'b100
	} state_t;

	state_t                         state_q;
	logic [ipq_pkg::ENTRIES-1:0]    valid_q;
	logic [ipq_pkg::STAMP_W-1:0]    arrival_q;
	ipq_pkg::entry_t                mem [ipq_pkg::ENTRIES];
	ipq_pkg::entry_t                rd_q;
	logic [ipq_pkg::IDX_W-1:0]      mem_addr;
	logic                           mem_we;
	ipq_pkg::entry_t                mem_wdata;
	logic [ipq_pkg::IDX_W-1:0]      cur_idx_q;
	logic [ipq_pkg::PRIO_W-1:0]     cur_amt_q;
	logic [ipq_pkg::IDX_W:0]        scan_q;
	logic                           pend_s1;
	logic                           vld_s1;
	logic [ipq_pkg::IDX_W-1:0]      idx_s1;
	logic                           found_q;
	logic [ipq_pkg::IDX_W-1:0]      best_idx_q;
	ipq_pkg::entry_t                best_q;
	ipq_pkg::rsp_t                  rsp_q;
	logic                           rsp_valid_q;
	logic                           start;
	logic                           live;
	logic                           scan_more;
	logic                           better;
	logic [ipq_pkg::PRIO_W:0]       sum;
	logic [ipq_pkg::PRIO_W-1:0]     sat;
	logic                           fin;
	ipq_pkg::rsp_t                  fin_rsp;

	assign cmd_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign start     = cmd_valid && cmd_ready;
	assign live      = cmd.in_range && valid_q[cmd.idx];
	assign scan_more = (scan_q != (ipq_pkg::IDX_W + 1)'(ipq_pkg::ENTRIES));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// saturate the raised priority
	assign sum = {1'b0, rd_q.prio} + {1'b0, cur_amt_q};
	assign sat = sum[ipq_pkg::PRIO_W] ? '1 : sum[ipq_pkg::PRIO_W-1:0];

	// compare the scanned entry with the best so far; lower index wins full ties
	assign better = pend_s1 && vld_s1 &&
		(!found_q || (rd_q.prio > best_q.prio) ||
		 ((rd_q.prio == best_q.prio) && (rd_q.stamp < best_q.stamp)));

	// drive the single memory port
	always_comb begin
		mem_addr        = cmd.idx;
		mem_we          = 1'b0;
		mem_wdata.prio  = cmd.amount;
		mem_wdata.stamp = arrival_q;
		case (state_q)
			S_IDLE: begin
				mem_we = start && (cmd.op == ipq_pkg::OP_INSERT) && cmd.in_range &&
					!valid_q[cmd.idx];
			end
			S_RAISE: begin
				mem_addr        = cur_idx_q;
				mem_we          = 1'b1;
				mem_wdata.prio  = sat;
				mem_wdata.stamp = rd_q.stamp;
			end
			S_SCAN: begin
				mem_addr = scan_q[ipq_pkg::IDX_W-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// write and read the table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	// build the result word of the finishing command
	always_comb begin
		fin     = 1'b0;
		fin_rsp = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.op)
						ipq_pkg::OP_INSERT: begin
							fin = 1'b1;
							if (!cmd.in_range) begin
								fin_rsp.status = ipq_pkg::STAT_UNKNOWN;
							end else if (live) begin
								fin_rsp.status = ipq_pkg::STAT_PRESENT;
							end else begin
								fin_rsp.status = ipq_pkg::STAT_OK;
							end
						end
						ipq_pkg::OP_RAISE: begin
							fin            = !live;
							fin_rsp.status = ipq_pkg::STAT_UNKNOWN;
						end
						ipq_pkg::OP_REMOVE: begin
							fin            = 1'b1;
							fin_rsp.status = live ? ipq_pkg::STAT_OK : ipq_pkg::STAT_UNKNOWN;
						end
						default: begin
							fin = 1'b0;
						end
					endcase
				end
			end
			S_RAISE: begin
				fin            = 1'b1;
				fin_rsp.status = ipq_pkg::STAT_OK;
			end
			S_SCAN: begin
				fin = !scan_more && !pend_s1;
				if (found_q) begin
					fin_rsp.status       = ipq_pkg::STAT_OK;
					fin_rsp.top_handle   = ipq_pkg::HANDLE_W'(best_idx_q);
					fin_rsp.top_priority = best_q.prio;
				end else begin
					fin_rsp.status = ipq_pkg::STAT_EMPTY;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// hold payload: operands, scan stage, best entry, result word
	always_ff @(posedge clk) begin
		if (start) begin
			cur_idx_q <= cmd.idx;
			cur_amt_q <= cmd.amount;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= scan_q[ipq_pkg::IDX_W-1:0];
			vld_s1 <= valid_q[scan_q[ipq_pkg::IDX_W-1:0]];
		end
		if (better) begin
			best_idx_q <= idx_s1;
			best_q     <= rd_q;
		end
		if (fin) begin
			rsp_q <= fin_rsp;
		end
	end

	// sequence commands, update valid bits and arrival counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			arrival_q   <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd.op)
							ipq_pkg::OP_INSERT: begin
								if (cmd.in_range && !live) begin
									valid_q[cmd.idx] <= 1'b1;
									arrival_q        <= arrival_q + 1'b1;
								end
							end
							ipq_pkg::OP_RAISE: begin
								if (live) begin
									state_q <= S_RAISE;
								end
							end
							ipq_pkg::OP_REMOVE: begin
								if (live) begin
									valid_q[cmd.idx] <= 1'b0;
								end
							end
							ipq_pkg::OP_QUERY: begin
								scan_q  <= '0;
								pend_s1 <= 1'b0;
								found_q <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_RAISE: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (scan_more) begin
						pend_s1 <= 1'b1;
						scan_q  <= scan_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/indexed_priority_queue_update_top.sv =====
// Insert, remove and rejected commands finish on acceptance in the back part, a raise after
// the raise state, a top query after scanning every entry, plus any wait in the command queue.
// Throughput: one command at a time in the back part, which waits for the result
// register to empty; a query walks the one-port entry table one entry a cycle.
// Reset: valid bits, arrival counter and all control clear at once; no clearing pass,
// the table holds garbage that is only read behind a set valid bit.
module indexed_priority_queue_update_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ipq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ipq_pkg::rsp_t rsp
);

	logic          push_valid;
	logic          push_ready;
	ipq_pkg::cmd_t push_cmd;
	logic          cmd_valid;
	logic          cmd_ready;
	ipq_pkg::cmd_t cmd;

	// classify incoming words
	ipq_front u_front (
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// decouple front from back
	ipq_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_ready),
		.pop_cmd    (cmd)
	);

	// carry out commands against the table
	ipq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/core/ipq_checker.sv =====
// Port-level checks for the indexed priority queue, bound to the top level.
`include "assert_macros.svh"

module ipq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input ipq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ipq_pkg::rsp_t rsp
);

	logic req_taken;
	logic rsp_busy;
	logic fail_nonzero;

	assign req_taken    = req_valid && req_ready;
	assign rsp_busy     = rsp_valid && !rsp_ready;
	assign fail_nonzero = (rsp.status != ipq_pkg::STAT_OK) &&
		((rsp.top_handle != '0) || (rsp.top_priority != '0));

	// a stalled result word holds
	`ASSERT_AT(a_rsp_hold, clk, arst_n, rsp_busy |=> (rsp_valid && $stable(rsp)))

	// results with a status other than OK carry zero handle and priority
	`ASSERT_NEVER(a_fail_zero, clk, arst_n, rsp_valid && fail_nonzero)

	// a reported top handle names a table slot
	`ASSERT_NEVER(a_top_range, clk, arst_n, rsp_valid && (int'(rsp.top_handle) >= ipq_pkg::ENTRIES))

	// an offered result word is fully known
	`ASSERT_NEVER(a_rsp_known, clk, arst_n, rsp_valid && $isunknown(rsp))

	// an accepted request word is fully known
	`ASSERT_NEVER(a_req_known, clk, arst_n, req_taken && $isunknown(req))

endmodule

bind indexed_priority_queue_update_top ipq_checker u_ipq_checker (.*);

// ===== tb/priority_table_checker.sv =====
// Checker that predicts and compares every reply of the indexed priority queue.
module priority_table_checker
	import ipq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   fail_count,
	output int   outstanding,
	output int   words_in,
	output int   tops_found,
	output int   rejects
);

	// shadow copy of the table and the arrival counter
	logic               live     [ENTRIES];
	logic [PRIO_W-1:0]  prio_of  [ENTRIES];
	logic [STAMP_W-1:0] stamp_of [ENTRIES];
	logic [STAMP_W-1:0] next_stamp;

	// replies owed by the block, oldest first
	rsp_t owed_replies [$];

	// apply one command word to the shadow table and return the reply it earns
	function automatic rsp_t apply_command(req_t w);
		rsp_t          r;
		int            h;
		int            best;
		logic          known;
		logic [PRIO_W:0] sum;
		r = '0;
		r.status = STAT_OK;
		h = int'(w.handle);
		known = (h < ENTRIES);
		case (w.op)
			OP_INSERT: begin
				if (!known) begin
					r.status = STAT_UNKNOWN;
				end else if (live[h]) begin
					r.status = STAT_PRESENT;
				end else begin
					live[h] = 1'b1;
					prio_of[h] = w.amount;
					stamp_of[h] = next_stamp;
					next_stamp = next_stamp + 1'b1;
				end
			end
			OP_RAISE: begin
				if (!known || !live[h]) begin
					r.status = STAT_UNKNOWN;
				end else begin
					// saturate at the largest priority, keep the stamp
					sum = {1'b0, prio_of[h]} + {1'b0, w.amount};
					prio_of[h] = sum[PRIO_W] ? '1 : sum[PRIO_W-1:0];
				end
			end
			OP_REMOVE: begin
				if (!known || !live[h])
					r.status = STAT_UNKNOWN;
				else
					live[h] = 1'b0;
			end
			default: begin
				// highest priority wins, then earliest stamp, then lowest handle
				best = -1;
				for (int i = 0; i < ENTRIES; i++) begin
					if (live[i] && (best < 0 || prio_of[i] > prio_of[best] ||
							(prio_of[i] == prio_of[best] && stamp_of[i] < stamp_of[best])))
						best = i;
				end
				if (best < 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.top_handle = HANDLE_W'(best);
					r.top_priority = prio_of[best];
					tops_found++;
				end
			end
		endcase
		if (r.status != STAT_OK)
			rejects++;
		return r;
	endfunction

	// count a bad reply, show the first few
	task automatic report(string what, rsp_t want, rsp_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected %s/%0d/%0d, got %s/%0d/%0d", $realtime, what,
				want.status.name(), want.top_handle, want.top_priority,
				got.status.name(), got.top_handle, got.top_priority);
	endtask

	// watch both channels: compare replies, then predict new words
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				live[i] = 1'b0;
			next_stamp = '0;
			owed_replies.delete();
			fail_count = 0;
			outstanding = 0;
			words_in = 0;
			tops_found = 0;
			rejects = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (owed_replies.size() == 0) begin
					report("reply with no command waiting", '0, rsp);
				end else begin
					want = owed_replies.pop_front();
					if (rsp.status !== want.status || rsp.top_handle !== want.top_handle ||
							rsp.top_priority !== want.top_priority)
						report("reply mismatch", want, rsp);
				end
			end
			if (req_valid && req_ready) begin
				owed_replies.push_back(apply_command(req));
				words_in++;
			end
			outstanding = owed_replies.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Regression top: clock, reset, command stimulus, reply pacing and verdict.
module testbench;
	import ipq_pkg::*;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	int fail_count;
	int outstanding;
	int words_in;
	int tops_found;
	int rejects;

	// calm turns off all idling near the end; long_hold asks for one long stall
	logic calm      = 1'b0;
	logic long_hold = 1'b0;

	always #5 clk = ~clk;

	indexed_priority_queue_update_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	priority_table_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.words_in    (words_in),
		.tops_found  (tops_found),
		.rejects     (rejects)
	);

	// watchdog
	initial begin
		#5_000_000;
		$display("indexed_priority_queue_update_top regression: fail");
		$finish;
	end

	function automatic req_t make_word(op_t o, int h, int a);
		req_t w;
		w.op = o;
		w.handle = HANDLE_W'(h);
		w.amount = PRIO_W'(a);
		return w;
	endfunction

	// hold the word until accepted, then maybe idle for a burst
	task automatic offer(req_t w);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// pace the reply side: short random stalls, one long hold-off on request
	initial begin
		int n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				rsp_ready <= 1'b0;
				for (n = 0; n < 300; n++)
					@(posedge clk);
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		int   i;
		int   pick;
		int   h;
		int   a;
		int   pool_lo;
		op_t  o;
		pool_lo = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, rejects, saturation, tie breaks, drain
		offer(make_word(OP_QUERY, 63, 16'hFFFF));
		offer(make_word(OP_RAISE, 3, 5));
		offer(make_word(OP_REMOVE, 3, 0));
		offer(make_word(OP_INSERT, 0, 0));
		offer(make_word(OP_INSERT, 63, 16'hFFFF));
		offer(make_word(OP_INSERT, 0, 7));
		offer(make_word(OP_QUERY, 0, 0));
		offer(make_word(OP_RAISE, 0, 16'hFFFF));
		offer(make_word(OP_QUERY, 21, 16'h5555));
		offer(make_word(OP_RAISE, 63, 1));
		offer(make_word(OP_INSERT, 21, 16'h5555));
		offer(make_word(OP_INSERT, 42, 16'hAAAA));
		offer(make_word(OP_RAISE, 42, 0));
		offer(make_word(OP_REMOVE, 0, 16'hFFFF));
		offer(make_word(OP_QUERY, 42, 16'hAAAA));
		offer(make_word(OP_REMOVE, 63, 0));
		offer(make_word(OP_QUERY, 0, 0));
		offer(make_word(OP_REMOVE, 63, 0));
		offer(make_word(OP_INSERT, 63, 16'hAAAA));
		offer(make_word(OP_QUERY, 0, 0));
		offer(make_word(OP_REMOVE, 42, 0));
		offer(make_word(OP_REMOVE, 21, 0));
		offer(make_word(OP_REMOVE, 63, 0));
		offer(make_word(OP_QUERY, 0, 0));

		// random: commands mostly on a sliding window of handles so entries live long
		for (i = 0; i < 1400; i++) begin
			calm = (i >= 1200);
			if (i == 400)
				long_hold = 1'b1;
			if (i % 100 == 0)
				pool_lo = $urandom_range(0, 63);
			pick = $urandom_range(0, 99);
			o = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_RAISE :
				(pick < 80) ? OP_REMOVE : OP_QUERY;
			if ($urandom_range(0, 3) == 0)
				h = $urandom_range(0, 63);
			else
				h = (pool_lo + $urandom_range(0, 15)) % (1 << HANDLE_W);
			case ($urandom_range(0, 5))
				0:       a = 0;
				1:       a = 16'hFFFF;
				2:       a = $urandom_range(0, 7);
				default: a = $urandom_range(0, 65535);
			endcase
			offer(make_word(o, h, a));
		end
		req_valid <= 1'b0;

		// drain, then leave room for a stray reply
		@(negedge clk);
		wait (outstanding == 0);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("Ran %0d commands: %0d top queries found an entry, %0d were refused,",
			words_in, tops_found, rejects);
		$display("with random idling on both sides and one long reply hold-off.");
		if (fail_count == 0)
			$display("indexed_priority_queue_update_top regression: pass");
		else
			$display("indexed_priority_queue_update_top regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ipq_pkg.sv
rtl/core/ipq_cmd_fifo.sv
rtl/core/ipq_front.sv
rtl/core/ipq_back.sv
rtl/core/indexed_priority_queue_update_top.sv
rtl/core/ipq_checker.sv
tb/priority_table_checker.sv
tb/testbench.sv
